/* src/sphk_pkg.sv */
// types and constants shared by the sph cubic spline kernel core
package sphk_pkg;

    localparam int COORD_W      = 32;
    localparam int FRAC_BITS    = 16;
    localparam int Q_BITS       = 30;
    localparam int H_W          = 31;
    localparam int OUT_W        = 32;
    localparam int SQ_W         = 2 * COORD_W;
    localparam int ROOT_W       = COORD_W;
    localparam int QV_W         = Q_BITS + 1;
    localparam int H2_W         = 2 * H_W;
    localparam int H3_W         = 3 * H_W;
    localparam int WEIGHT_SHIFT = 62 - 3 * FRAC_BITS;
    localparam int GRAD_SHIFT   = 4 * FRAC_BITS - 62;

    localparam logic [H_W-1:0]  NORM_Q32 = 31'd1953043645;
    localparam logic [H_W-1:0]  H_RESET  = 31'd65536;
    localparam logic [H2_W-1:0] H2_RESET = 62'd4294967296;
    localparam logic [SQ_W-1:0] SQ_RESET = 64'd17179869184;
    localparam logic [H3_W-1:0] H3_RESET = 93'd281474976710656;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
    } pair_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] weight;
        logic signed [OUT_W-1:0] grad_x;
        logic signed [OUT_W-1:0] grad_y;
        logic                    in_support;
    } result_t;

endpackage

/* src/sph_cubic_spline_kernel_2d_core.sv */
// sph 2d cubic spline kernel: value and gradient for one particle pair per cycle while not busy
// throughput: one pair per cycle while busy is low; busy is high after a
// smoothing length write, while h^2, (2h)^2 and h^3 are formed by one 31x31 multiplier
// pipeline runs through the 32-stage square root and two 31-stage divider chains
// reset: pipeline empty, smoothing length 1.0; results cannot be stalled
module sph_cubic_spline_kernel_2d_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  sphk_pkg::pair_t           pair,
    input  logic                      cfg_we,
    input  logic [sphk_pkg::H_W-1:0]  cfg_wdata,
    output logic                      done,
    output sphk_pkg::result_t         result
);

    import sphk_pkg::*;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_SQ,
        DRV_LO,
        DRV_HI,
        DRV_SUM
    } drv_state_t;

    typedef struct packed {
        logic [COORD_W-1:0] adx;
        logic [COORD_W-1:0] ady;
        logic               xneg;
        logic               yneg;
        logic               sup;
    } sq_side_t;

    typedef struct packed {
        logic [QV_W-1:0] ux;
        logic [QV_W-1:0] uy;
        logic            xneg;
        logic            yneg;
        logic            sup;
        logic            rzero;
    } carry_t;

    // smoothing length and derived values
    drv_state_t      drv_state_reg;
    logic [H_W-1:0]  h_reg;
    logic [H2_W-1:0] h2_reg;
    logic [SQ_W-1:0] sup_sq_reg;
    logic [H3_W-1:0] h3_reg;
    logic [H2_W-1:0] plo_reg;
    logic [H2_W-1:0] phi_reg;
    logic [H2_W-1:0] hmul;
    logic [H_W-1:0]  hmul_a;

    always_comb
    begin
        case (drv_state_reg)
            DRV_LO:  hmul_a = h2_reg[H_W-1:0];
            DRV_HI:  hmul_a = h2_reg[H2_W-1:H_W];
            default: hmul_a = h_reg;
        endcase
    end

    assign hmul = H2_W'(hmul_a) * H2_W'(h_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_state_reg <= DRV_IDLE;
            h_reg         <= H_RESET;
            h2_reg        <= H2_RESET;
            sup_sq_reg    <= SQ_RESET;
            h3_reg        <= H3_RESET;
            plo_reg       <= '0;
            phi_reg       <= '0;
        end
        else if (cfg_we)
        begin
            h_reg         <= (cfg_wdata == '0) ? H_W'(1) : cfg_wdata;
            drv_state_reg <= DRV_SQ;
        end
        else
        begin
            case (drv_state_reg)
                DRV_SQ:
                begin
                    h2_reg        <= hmul;
                    sup_sq_reg    <= {hmul, 2'b00};
                    drv_state_reg <= DRV_LO;
                end
                DRV_LO:
                begin
                    plo_reg       <= hmul;
                    drv_state_reg <= DRV_HI;
                end
                DRV_HI:
                begin
                    phi_reg       <= hmul;
                    drv_state_reg <= DRV_SUM;
                end
                DRV_SUM:
                begin
                    h3_reg        <= H3_W'(plo_reg) + (H3_W'(phi_reg) << H_W);
                    drv_state_reg <= DRV_IDLE;
                end
                default:
                begin
                    drv_state_reg <= DRV_IDLE;
                end
            endcase
        end
    end

    assign busy = (drv_state_reg != DRV_IDLE);

    // separation, magnitude, squares, support test
    logic                 a_vld_reg;
    logic [COORD_W:0]     a_dx_reg;
    logic [COORD_W:0]     a_dy_reg;
    logic                 b_vld_reg;
    logic [COORD_W-1:0]   b_adx_reg;
    logic [COORD_W-1:0]   b_ady_reg;
    logic                 b_xneg_reg;
    logic                 b_yneg_reg;
    logic                 c_vld_reg;
    logic [SQ_W-1:0]      c_sx_reg;
    logic [SQ_W-1:0]      c_sy_reg;
    logic [COORD_W-1:0]   c_adx_reg;
    logic [COORD_W-1:0]   c_ady_reg;
    logic                 c_xneg_reg;
    logic                 c_yneg_reg;
    logic                 d_vld_reg;
    logic [SQ_W-1:0]      d_r2_reg;
    sq_side_t             d_side_reg;

    logic [COORD_W:0]     a_dx_next;
    logic [COORD_W:0]     a_dy_next;
    logic [COORD_W:0]     b_nx;
    logic [COORD_W:0]     b_ny;
    logic [SQ_W:0]        d_r2_full;

    assign a_dx_next = {pair.first_x[COORD_W-1], pair.first_x}
                     - {pair.second_x[COORD_W-1], pair.second_x};
    assign a_dy_next = {pair.first_y[COORD_W-1], pair.first_y}
                     - {pair.second_y[COORD_W-1], pair.second_y};
    assign b_nx      = (COORD_W+1)'(0) - a_dx_reg;
    assign b_ny      = (COORD_W+1)'(0) - a_dy_reg;
    assign d_r2_full = {1'b0, c_sx_reg} + {1'b0, c_sy_reg};

    always_ff @(posedge clk)
    begin
        a_dx_reg        <= a_dx_next;
        a_dy_reg        <= a_dy_next;
        b_adx_reg       <= a_dx_reg[COORD_W] ? b_nx[COORD_W-1:0] : a_dx_reg[COORD_W-1:0];
        b_ady_reg       <= a_dy_reg[COORD_W] ? b_ny[COORD_W-1:0] : a_dy_reg[COORD_W-1:0];
        b_xneg_reg      <= a_dx_reg[COORD_W];
        b_yneg_reg      <= a_dy_reg[COORD_W];
        c_sx_reg        <= SQ_W'(b_adx_reg) * SQ_W'(b_adx_reg);
        c_sy_reg        <= SQ_W'(b_ady_reg) * SQ_W'(b_ady_reg);
        c_adx_reg       <= b_adx_reg;
        c_ady_reg       <= b_ady_reg;
        c_xneg_reg      <= b_xneg_reg;
        c_yneg_reg      <= b_yneg_reg;
        d_r2_reg        <= d_r2_full[SQ_W-1:0];
        d_side_reg.adx  <= c_adx_reg;
        d_side_reg.ady  <= c_ady_reg;
        d_side_reg.xneg <= c_xneg_reg;
        d_side_reg.yneg <= c_yneg_reg;
        d_side_reg.sup  <= d_r2_full < {1'b0, sup_sq_reg};
    end

    // integer square root, one result bit per stage
    logic              sq_vld_reg  [ROOT_W];
    logic [SQ_W-1:0]   sq_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] sq_root_reg [ROOT_W];
    sq_side_t          sq_side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        localparam int B = ROOT_W - 1 - k;

        logic              vld_in;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        sq_side_t          side_in;
        logic [SQ_W:0]     trial;
        logic              hit;

        if (k == 0) begin : g_first
            assign vld_in  = d_vld_reg;
            assign rem_in  = d_r2_reg;
            assign root_in = '0;
            assign side_in = d_side_reg;
        end else begin : g_next
            assign vld_in  = sq_vld_reg[k-1];
            assign rem_in  = sq_rem_reg[k-1];
            assign root_in = sq_root_reg[k-1];
            assign side_in = sq_side_reg[k-1];
        end

        assign trial = ((SQ_W+1)'(root_in) << (B + 1)) | ((SQ_W+1)'(1) << (2 * B));
        assign hit   = {1'b0, rem_in} >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            sq_rem_reg[k]  <= hit ? (rem_in - trial[SQ_W-1:0]) : rem_in;
            sq_root_reg[k] <= hit ? (root_in | (ROOT_W'(1) << B)) : root_in;
            sq_side_reg[k] <= side_in;
        end
    end

    // q = r/h and unit direction |d|/r
    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    sq_side_t          sq_side;
    logic              qd_vld;
    logic              uxd_vld;
    logic              uyd_vld;
    logic [QV_W-1:0]   qd_quo;
    logic [QV_W-1:0]   uxd_quo;
    logic [QV_W-1:0]   uyd_quo;
    logic [1:0]        qd_side;
    logic              uxd_side;
    logic              uyd_side;

    assign sq_vld  = sq_vld_reg[ROOT_W-1];
    assign sq_root = sq_root_reg[ROOT_W-1];
    assign sq_side = sq_side_reg[ROOT_W-1];

    sphk_div #(
        .NW (ROOT_W + Q_BITS),
        .DW (H_W),
        .QW (QV_W),
        .SW (2)
    ) u_qdiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sq_vld),
        .in_dividend  ({sq_root, Q_BITS'(0)}),
        .in_divisor   (h_reg),
        .in_side      ({sq_side.sup, (sq_root == '0)}),
        .out_valid    (qd_vld),
        .out_quotient (qd_quo),
        .out_side     (qd_side)
    );

    sphk_div #(
        .NW (COORD_W + Q_BITS),
        .DW (ROOT_W),
        .QW (QV_W),
        .SW (1)
    ) u_uxdiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sq_vld),
        .in_dividend  ({sq_side.adx, Q_BITS'(0)}),
        .in_divisor   (sq_root),
        .in_side      (sq_side.xneg),
        .out_valid    (uxd_vld),
        .out_quotient (uxd_quo),
        .out_side     (uxd_side)
    );

    sphk_div #(
        .NW (COORD_W + Q_BITS),
        .DW (ROOT_W),
        .QW (QV_W),
        .SW (1)
    ) u_uydiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (sq_vld),
        .in_dividend  ({sq_side.ady, Q_BITS'(0)}),
        .in_divisor   (sq_root),
        .in_side      (sq_side.yneg),
        .out_valid    (uyd_vld),
        .out_quotient (uyd_quo),
        .out_side     (uyd_side)
    );

    // kernel polynomial and gradient magnitude
    logic              p1_vld_reg, p2_vld_reg, p3_vld_reg, p4_vld_reg;
    logic              p5_vld_reg, p6_vld_reg, p7_vld_reg;
    carry_t            p1_c_reg, p2_c_reg, p3_c_reg, p4_c_reg, p5_c_reg;
    logic              p1_inner_reg, p2_inner_reg, p3_inner_reg;
    logic [QV_W-1:0]   p1_q_reg, p2_q_reg, p3_q_reg;
    logic [QV_W-1:0]   p1_base_reg, p2_base_reg;
    logic [QV_W-1:0]   p2_b2_reg, p3_b2_reg;
    logic [QV_W-1:0]   p3_b3_reg;
    logic [QV_W-1:0]   p4_fm_reg;
    logic [OUT_W-1:0]  p4_gmag_reg;
    logic [46:0]       p5_wd_reg, p6_wd_reg, p7_wd_reg;
    logic [32:0]       p5_gm_reg;
    logic [SQ_W-1:0]   p6_gxd_reg, p6_gyd_reg, p7_gxd_reg, p7_gyd_reg;
    logic              p6_sup_reg, p6_gzero_reg, p6_negx_reg, p6_negy_reg;
    logic              p7_sup_reg, p7_gzero_reg, p7_negx_reg, p7_negy_reg;
    logic              p7_ovw_reg, p7_ovx_reg, p7_ovy_reg;

    carry_t            p1_c_next;
    logic [QV_W:0]     p1_t;
    logic [H2_W-1:0]   p2_prod;
    logic [H2_W-1:0]   p3_prod;
    logic [33:0]       p4_t1, p4_t2, p4_f, p4_gin;
    logic [H2_W-1:0]   p5_wprod;
    logic [H2_W:0]     p5_gprod;
    logic [SQ_W-1:0]   p6_gxp, p6_gyp;

    always_comb
    begin
        p1_c_next.ux    = uxd_quo;
        p1_c_next.uy    = uyd_quo;
        p1_c_next.xneg  = uxd_side;
        p1_c_next.yneg  = uyd_side;
        p1_c_next.sup   = qd_side[1];
        p1_c_next.rzero = qd_side[0];
    end

    assign p1_t     = (QV_W+1)'(1) << QV_W;
    assign p2_prod  = H2_W'(p1_base_reg) * H2_W'(p1_base_reg);
    assign p3_prod  = H2_W'(p2_b2_reg) * H2_W'(p2_base_reg);
    assign p4_t1    = (34'(p3_b2_reg) * 34'd3) >> 1;
    assign p4_t2    = (34'(p3_b3_reg) * 34'd3) >> 2;
    assign p4_f     = (34'd1 << Q_BITS) + p4_t2 - p4_t1;
    assign p4_gin   = 34'(p3_q_reg) * 34'd3 - ((34'(p3_b2_reg) * 34'd9) >> 2);
    assign p5_wprod = H2_W'(NORM_Q32) * H2_W'(p4_fm_reg);
    assign p5_gprod = (H2_W+1)'(NORM_Q32) * (H2_W+1)'(p4_gmag_reg);
    assign p6_gxp   = SQ_W'(p5_gm_reg) * SQ_W'(p5_c_reg.ux);
    assign p6_gyp   = SQ_W'(p5_gm_reg) * SQ_W'(p5_c_reg.uy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            d_vld_reg  <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
            p7_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg  <= start && !busy;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            d_vld_reg  <= c_vld_reg;
            p1_vld_reg <= qd_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
            p7_vld_reg <= p6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_c_reg     <= p1_c_next;
        p1_inner_reg <= !qd_quo[Q_BITS];
        p1_q_reg     <= qd_quo;
        p1_base_reg  <= qd_quo[Q_BITS] ? QV_W'(p1_t - {1'b0, qd_quo}) : qd_quo;

        p2_c_reg     <= p1_c_reg;
        p2_inner_reg <= p1_inner_reg;
        p2_q_reg     <= p1_q_reg;
        p2_base_reg  <= p1_base_reg;
        p2_b2_reg    <= p2_prod[Q_BITS +: QV_W];

        p3_c_reg     <= p2_c_reg;
        p3_inner_reg <= p2_inner_reg;
        p3_q_reg     <= p2_q_reg;
        p3_b2_reg    <= p2_b2_reg;
        p3_b3_reg    <= p3_prod[Q_BITS +: QV_W];

        p4_c_reg     <= p3_c_reg;
        if (p3_inner_reg)
        begin
            p4_fm_reg   <= p4_f[33] ? '0 : p4_f[QV_W-1:0];
            p4_gmag_reg <= p4_gin[OUT_W-1:0];
        end
        else
        begin
            p4_fm_reg   <= p3_b3_reg >> 2;
            p4_gmag_reg <= OUT_W'((34'(p3_b2_reg) * 34'd3) >> 2);
        end

        p5_c_reg     <= p4_c_reg;
        p5_wd_reg    <= 47'(p5_wprod >> WEIGHT_SHIFT);
        p5_gm_reg    <= 33'(p5_gprod >> Q_BITS);

        p6_wd_reg    <= p5_wd_reg;
        p6_gxd_reg   <= p6_gxp << GRAD_SHIFT;
        p6_gyd_reg   <= p6_gyp << GRAD_SHIFT;
        p6_sup_reg   <= p5_c_reg.sup;
        p6_gzero_reg <= !p5_c_reg.sup || p5_c_reg.rzero;
        p6_negx_reg  <= !p5_c_reg.xneg;
        p6_negy_reg  <= !p5_c_reg.yneg;

        p7_wd_reg    <= p6_wd_reg;
        p7_gxd_reg   <= p6_gxd_reg;
        p7_gyd_reg   <= p6_gyd_reg;
        p7_sup_reg   <= p6_sup_reg;
        p7_gzero_reg <= p6_gzero_reg;
        p7_negx_reg  <= p6_negx_reg;
        p7_negy_reg  <= p6_negy_reg;
        p7_ovw_reg   <= H2_W'(p6_wd_reg >> (OUT_W - 1)) >= h2_reg;
        p7_ovx_reg   <= H3_W'(p6_gxd_reg >> (OUT_W - 1)) >= h3_reg;
        p7_ovy_reg   <= H3_W'(p6_gyd_reg >> (OUT_W - 1)) >= h3_reg;
    end

    // divisions by h^2 and h^3
    logic              wd_vld, gxd_vld, gyd_vld;
    logic [QV_W-1:0]   wd_quo, gxd_quo, gyd_quo;
    logic [1:0]        wd_side;
    logic [2:0]        gxd_side;
    logic [1:0]        gyd_side;

    sphk_div #(
        .NW (47),
        .DW (H2_W),
        .QW (QV_W),
        .SW (2)
    ) u_wdiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (p7_vld_reg),
        .in_dividend  (p7_wd_reg),
        .in_divisor   (h2_reg),
        .in_side      ({p7_sup_reg, p7_ovw_reg}),
        .out_valid    (wd_vld),
        .out_quotient (wd_quo),
        .out_side     (wd_side)
    );

    sphk_div #(
        .NW (SQ_W),
        .DW (H3_W),
        .QW (QV_W),
        .SW (3)
    ) u_gxdiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (p7_vld_reg),
        .in_dividend  (p7_gxd_reg),
        .in_divisor   (h3_reg),
        .in_side      ({p7_gzero_reg, p7_ovx_reg, p7_negx_reg}),
        .out_valid    (gxd_vld),
        .out_quotient (gxd_quo),
        .out_side     (gxd_side)
    );

    sphk_div #(
        .NW (SQ_W),
        .DW (H3_W),
        .QW (QV_W),
        .SW (2)
    ) u_gydiv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (p7_vld_reg),
        .in_dividend  (p7_gyd_reg),
        .in_divisor   (h3_reg),
        .in_side      ({p7_ovy_reg, p7_negy_reg}),
        .out_valid    (gyd_vld),
        .out_quotient (gyd_quo),
        .out_side     (gyd_side)
    );

    // saturation and output register
    localparam logic [OUT_W-1:0] POS_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] NEG_MAX = {1'b1, {(OUT_W-1){1'b0}}};

    logic       done_reg;
    result_t    result_reg;
    result_t    result_next;
    logic [OUT_W-1:0] gx_pos, gy_pos;

    assign gx_pos = {1'b0, gxd_quo};
    assign gy_pos = {1'b0, gyd_quo};

    always_comb
    begin
        result_next.in_support = wd_side[1];
        if (!wd_side[1])
        begin
            result_next.weight = '0;
        end
        else if (wd_side[0])
        begin
            result_next.weight = POS_MAX;
        end
        else
        begin
            result_next.weight = {1'b0, wd_quo};
        end

        if (gxd_side[2])
        begin
            result_next.grad_x = '0;
            result_next.grad_y = '0;
        end
        else
        begin
            if (gxd_side[1])
            begin
                result_next.grad_x = gxd_side[0] ? NEG_MAX : POS_MAX;
            end
            else
            begin
                result_next.grad_x = gxd_side[0] ? (OUT_W'(0) - gx_pos) : gx_pos;
            end
            if (gyd_side[1])
            begin
                result_next.grad_y = gyd_side[0] ? NEG_MAX : POS_MAX;
            end
            else
            begin
                result_next.grad_y = gyd_side[0] ? (OUT_W'(0) - gy_pos) : gy_pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= wd_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_front_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        (qd_vld == uxd_vld) && (qd_vld == uyd_vld))
        else $error("q and direction dividers out of step");

    a_back_div_align: assert property (@(posedge clk) disable iff (!rst_n)
        (wd_vld == gxd_vld) && (wd_vld == gyd_vld))
        else $error("weight and gradient dividers out of step");

    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("no derive pass after smoothing length write");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.in_support) |->
        (result.weight == '0) && (result.grad_x == '0) && (result.grad_y == '0))
        else $error("nonzero result outside support");

    a_weight_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !result.weight[OUT_W-1])
        else $error("negative kernel value");

endmodule

/* src/sphk_div.sv */
// pipelined restoring divider, one quotient bit per stage, with sideband
module sphk_div #(
    parameter int NW = 62,
    parameter int DW = 31,
    parameter int QW = 31,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NW-1:0] in_dividend,
    input  logic [DW-1:0] in_divisor,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QW-1:0] out_quotient,
    output logic [SW-1:0] out_side
);

    localparam int CW = (NW > DW) ? NW : DW;
    localparam int EW = NW + DW;

    logic          vld_reg  [QW];
    logic [NW-1:0] rem_reg  [QW];
    logic [DW-1:0] dvs_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int BIT = QW - 1 - k;

        logic          vld_in;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] dvs_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_in;
        logic [CW-1:0] shr;
        logic [CW-1:0] dext;
        logic [EW-1:0] dsh;
        logic          hit;
        logic [QW-1:0] quo_new;

        if (k == 0) begin : g_first
            assign vld_in  = in_valid;
            assign rem_in  = in_dividend;
            assign dvs_in  = in_divisor;
            assign quo_in  = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign shr  = CW'(rem_in >> BIT);
        assign dext = CW'(dvs_in);
        assign hit  = shr >= dext;
        assign dsh  = EW'(dvs_in) << BIT;

        always_comb
        begin
            quo_new      = quo_in;
            quo_new[BIT] = hit;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= hit ? (rem_in - dsh[NW-1:0]) : rem_in;
            dvs_reg[k]  <= dvs_in;
            quo_reg[k]  <= quo_new;
            side_reg[k] <= side_in;
        end
    end

    assign out_valid    = vld_reg[QW-1];
    assign out_quotient = quo_reg[QW-1];
    assign out_side     = side_reg[QW-1];

endmodule
